@@ design/csv_tok_pkg.sv @@
// ----------------------------------------------------------------------------
// csv_tok_pkg
// Shared widths, character codes and record types for the CSV tokenizer.
// ----------------------------------------------------------------------------
package csv_tok_pkg;

  localparam int DATA_W           = 8;
  localparam int LINE_COUNT_WIDTH = 24;
  localparam int LINE_NUM_W       = 24;
  localparam int TDATA_W          = DATA_W + LINE_NUM_W;
  localparam int TUSER_W          = 3;

  localparam logic [DATA_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [DATA_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [DATA_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [DATA_W-1:0] CH_LOWER_N = 8'h6E;
  localparam logic [DATA_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [DATA_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [DATA_W-1:0] CH_NUL     = 8'h00;

  // parser state carried from beat to beat
  typedef struct packed {
    logic                        field_started;
    logic                        in_quotes;
    logic                        escape_pending;
    logic                        error_seen;
    logic [LINE_COUNT_WIDTH-1:0] line_counter;
  } tok_state_t;

  // one result beat
  typedef struct packed {
    logic                  char_valid;
    logic [DATA_W-1:0]     char_out;
    logic                  field_done;
    logic                  line_done;
    logic                  format_error;
    logic [LINE_NUM_W-1:0] line_number;
  } tok_result_t;

endpackage

@@ design/csv_tok_core.sv @@
// ----------------------------------------------------------------------------
// csv_tok_core
// Per-character parse step: next parser state and the result for one byte.
// ----------------------------------------------------------------------------
module csv_tok_core import csv_tok_pkg::*; (
  input  tok_state_t        st,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              last_in_line,
  input  logic              escape_enable,
  output tok_state_t        st_next,
  output tok_result_t       res
);

  logic              cv;
  logic [DATA_W-1:0] co;
  logic              fd;
  logic              ld;
  logic              fail;

  always_comb begin
    st_next = st;
    cv      = 1'b0;
    co      = CH_NUL;
    fd      = 1'b0;
    ld      = 1'b0;
    fail    = 1'b0;

    if (!st.error_seen) begin
      priority if (!st.field_started) begin
        if (data_byte == CH_QUOTE) begin
          st_next.in_quotes     = 1'b1;
          st_next.field_started = 1'b1;
          fail                  = last_in_line;
        end else if (data_byte == CH_COMMA) begin
          fd = 1'b1;                       // empty field
        end else begin
          cv                    = 1'b1;
          co                    = data_byte;
          st_next.field_started = 1'b1;
          fd                    = last_in_line;
        end
      end else if (!st.in_quotes) begin
        if (data_byte == CH_COMMA) begin
          fd                    = 1'b1;
          st_next.field_started = 1'b0;
        end else begin
          cv = 1'b1;
          co = data_byte;
          fd = last_in_line;
        end
      end else if (st.escape_pending) begin
        st_next.escape_pending = 1'b0;
        priority if (data_byte == CH_BSLASH || data_byte == CH_QUOTE) begin
          cv = 1'b1;
          co = data_byte;
        end else if (data_byte == CH_LOWER_N) begin
          cv = 1'b1;
          co = CH_NEWLINE;
        end else if (data_byte == CH_DIGIT_0) begin
          cv = 1'b1;
          co = CH_NUL;
        end else begin
          cv = 1'b0;                       // unknown escape dropped
        end
        fail = last_in_line;
      end else if (data_byte == CH_QUOTE) begin
        st_next.in_quotes = 1'b0;
        fd                = last_in_line;
      end else if (data_byte == CH_BSLASH && escape_enable) begin
        st_next.escape_pending = 1'b1;
        fail                   = last_in_line;
      end else begin
        cv   = 1'b1;
        co   = data_byte;
        fail = last_in_line;
      end

      if (fail) begin
        cv                 = 1'b0;
        co                 = CH_NUL;
        fd                 = 1'b0;
        ld                 = 1'b1;
        st_next.error_seen = 1'b1;
      end else if (last_in_line) begin
        ld                     = 1'b1;
        st_next.field_started  = 1'b0;
        st_next.in_quotes      = 1'b0;
        st_next.escape_pending = 1'b0;
        if (st.line_counter != {LINE_COUNT_WIDTH{1'b1}}) begin
          st_next.line_counter = st.line_counter + LINE_COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_comb begin
    res.char_valid   = cv;
    res.char_out     = co;
    res.field_done   = fd;
    res.line_done    = ld;
    res.format_error = st_next.error_seen;
    res.line_number  = LINE_NUM_W'(st.line_counter);
  end

endmodule

@@ design/csv_tok_out_stage.sv @@
// ----------------------------------------------------------------------------
// csv_tok_out_stage
// Result register with valid/ready; takes a new beat when empty or draining.
// ----------------------------------------------------------------------------
module csv_tok_out_stage import csv_tok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  tok_result_t res_in,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output tok_result_t out_res
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_res <= res_in;
    end
  end

endmodule

@@ design/csv_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// csv_field_tokenizer - streaming CSV field tokenizer with backslash escapes
// From input beat accept to result beat valid the path is the input register,
// then the result register. Throughput: one character per cycle while the
// sink accepts; a stalled sink holds the input side.
// Reset (rst, sync, active high): parser state, line count, escape enable,
// and both stage valids clear; no clearing pass.
// ----------------------------------------------------------------------------
module csv_field_tokenizer import csv_tok_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration: escape_enable
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tlast,   // last_in_line
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] char_out, [31:8] line_number
  output logic [TUSER_W-1:0] m_axis_tuser,   // [0] char_valid, [1] field_done,
                                             // [2] format_error
  output logic               m_axis_tlast    // line_done
);

  // Input register: one character waiting to be parsed.
  logic              in_valid;
  logic [DATA_W-1:0] in_byte;
  logic              in_last;

  // Parser state and config.
  tok_state_t  state;
  tok_state_t  state_next;
  logic        escape_enable;

  tok_result_t step_res;
  tok_result_t out_res;
  logic        can_load;
  logic        advance;

  // A character is parsed, and the state moves, in the cycle it leaves the
  // input register for the result register.
  assign advance       = in_valid && can_load;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b0;
    end else if (cfg_we) begin
      escape_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  csv_tok_core u_core (
    .st            (state),
    .data_byte     (in_byte),
    .last_in_line  (in_last),
    .escape_enable (escape_enable),
    .st_next       (state_next),
    .res           (step_res)
  );

  csv_tok_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (step_res),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result beat.
  assign m_axis_tdata = {out_res.line_number, out_res.char_out};
  assign m_axis_tuser = {out_res.format_error, out_res.field_done, out_res.char_valid};
  assign m_axis_tlast = out_res.line_done;

`ifndef NO_ASSERTIONS
  // once an error is latched it stays until reset
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    state.error_seen |=> state.error_seen)
    else $error("error flag cleared without reset");

  // line count frozen after an error
  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    state.error_seen |=> $stable(state.line_counter))
    else $error("line count moved after error");

  // a pending escape only exists inside quotes, quotes only inside a field
  a_escape_in_quotes: assert property (@(posedge clk) disable iff (rst)
    state.escape_pending |-> state.in_quotes)
    else $error("escape pending outside quotes");

  a_quotes_in_field: assert property (@(posedge clk) disable iff (rst)
    state.in_quotes |-> state.field_started)
    else $error("quoted mode outside a field");

  // a completed field never carries the error mark
  a_field_no_error: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.field_done) |-> !out_res.format_error)
    else $error("field end reported with error");
`endif

endmodule
